// ===== hdl/masked_5x5_normalized_shadow_filter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the masked 5x5 shadow filter unit.
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef MASKED_5X5_NORMALIZED_SHADOW_FILTER_UNIT_ASSERT_SVH
`define MASKED_5X5_NORMALIZED_SHADOW_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// The expression must never be true at a clock edge outside reset.
`define MSNSF_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: never");
// The consequent must hold in the cycle after the antecedent.
`define MSNSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next");
`else
`define MSNSF_ASSERT_NEVER(label, clk, rst_n, expr)
`define MSNSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/msnsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msnsf_pkg
// Shared constants and the kernel weight table of the shadow filter.
// ----------------------------------------------------------------------------
package msnsf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int KERNEL_SIZE    = 5;
    localparam int KERNEL_TAPS    = KERNEL_SIZE * KERNEL_SIZE;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam int RESET_DIM = 64;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 12;
    localparam int WEIGHT_W   = 8;

    // Distinct weights of the symmetric kernel, by distance from the center.
    localparam logic [WEIGHT_W-1:0] WT_22 = 8'd58;
    localparam logic [WEIGHT_W-1:0] WT_21 = 8'd85;
    localparam logic [WEIGHT_W-1:0] WT_20 = 8'd96;
    localparam logic [WEIGHT_W-1:0] WT_11 = 8'd123;
    localparam logic [WEIGHT_W-1:0] WT_10 = 8'd140;
    localparam logic [WEIGHT_W-1:0] WT_00 = 8'd159;

    // Weight of kernel tap (row, col), each 0..4.
    function automatic logic [WEIGHT_W-1:0] kernel_weight(input logic [2:0] ky,
                                                          input logic [2:0] kx);
        logic [1:0] dr;
        logic [1:0] dc;
        logic [1:0] a;
        logic [1:0] b;
        dr = (ky > 3'd2) ? 2'(ky - 3'd2) : 2'(3'd2 - ky);
        dc = (kx > 3'd2) ? 2'(kx - 3'd2) : 2'(3'd2 - kx);
        a  = (dr > dc) ? dr : dc;
        b  = (dr > dc) ? dc : dr;
        case ({a, b})
            4'b1010: kernel_weight = WT_22;
            4'b1001: kernel_weight = WT_21;
            4'b1000: kernel_weight = WT_20;
            4'b0101: kernel_weight = WT_11;
            4'b0100: kernel_weight = WT_10;
            default: kernel_weight = WT_00;
        endcase
    endfunction

endpackage

// ===== hdl/msnsf_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msnsf_fifo
// Short queue of pending result jobs between the front and back parts.
// ----------------------------------------------------------------------------
module msnsf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wptr_reg + 1'b1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNTW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNTW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/msnsf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msnsf_front
// Accepts items, writes texels to the texel store and queues result jobs.
// ----------------------------------------------------------------------------
module msnsf_front #(
    parameter int MAX_WIDTH  = msnsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = msnsf_pkg::DEF_MAX_HEIGHT,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT + 1),
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1),
    parameter int AW = $clog2(4 * MAX_WIDTH + 8),
    parameter int EW = XW + YW + AW + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           command,
    input  logic                           texel_mapped,
    input  logic                           texel_visible,
    input  logic                           cfg_we,
    input  logic [msnsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msnsf_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                           q_full,
    output logic                           q_push,
    output logic [EW-1:0]                  q_data,
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic [1:0]                     wr_data,
    output logic [WW-1:0]                  eff_w,
    output logic [HW-1:0]                  eff_h,
    output logic                           cfg_clear
);
    import msnsf_pkg::*;

    localparam int DEPTH = 4 * MAX_WIDTH + 8;
    localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int RST_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
    localparam int RST_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

    logic [WW-1:0]    w_reg;
    logic [HW-1:0]    h_reg;
    logic [CW-1:0]    in_cnt_reg;
    logic [AW-1:0]    in_addr_reg;
    logic [CW-1:0]    enq_cnt_reg;
    logic [XW-1:0]    ox_reg;
    logic [YW-1:0]    oy_reg;
    logic [AW-1:0]    caddr_reg;
    logic [WW+HW-1:0] prod;
    logic [CW-1:0]    total;
    logic [WW+1:0]    lag;
    logic             acc;
    logic             tex_ok;
    logic             tex_emit;
    logic             drain_emit;
    logic             is_last;
    logic             cfg_hit;

    // Frame geometry from the clamped registers.
    assign prod  = WW'(w_reg) * HW'(h_reg);
    assign total = CW'(prod);
    assign lag   = (WW+2)'({w_reg, 1'b0}) + (WW+2)'(2);
    assign eff_w = w_reg;
    assign eff_h = h_reg;

    // Item classification.
    assign in_ready   = !q_full;
    assign acc        = in_valid && !q_full;
    assign tex_ok     = acc && !command && (in_cnt_reg < total);
    assign tex_emit   = tex_ok && (in_cnt_reg >= lag);
    assign drain_emit = acc && command && (in_cnt_reg >= total) && (enq_cnt_reg < total);
    assign is_last    = (enq_cnt_reg == CW'(total - 1'b1));
    assign q_push     = tex_emit || drain_emit;
    assign q_data     = {is_last, caddr_reg, oy_reg, ox_reg};

    assign wr_en   = tex_ok;
    assign wr_addr = in_addr_reg;
    assign wr_data = {texel_mapped & texel_visible, texel_mapped};

    assign cfg_hit   = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);
    assign cfg_clear = cfg_hit;

    // Configuration registers, clamped on write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= WW'(RST_W);
            h_reg <= HW'(RST_H);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IMAGE_WIDTH)
            begin
                if (cfg_wdata == '0)
                    w_reg <= WW'(1);
                else if (cfg_wdata > MAX_WIDTH)
                    w_reg <= WW'(MAX_WIDTH);
                else
                    w_reg <= WW'(cfg_wdata);
            end
            else if (cfg_index == CFG_IMAGE_HEIGHT)
            begin
                if (cfg_wdata == '0)
                    h_reg <= HW'(1);
                else if (cfg_wdata > MAX_HEIGHT)
                    h_reg <= HW'(MAX_HEIGHT);
                else
                    h_reg <= HW'(cfg_wdata);
            end
        end
    end

    // Input and job counters. The store addresses run on across frames, so
    // texels of a new frame never overwrite those that jobs of the previous
    // frame still read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            in_addr_reg <= '0;
            enq_cnt_reg <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            caddr_reg   <= '0;
        end
        else if (cfg_hit)
        begin
            in_cnt_reg  <= '0;
            in_addr_reg <= '0;
            enq_cnt_reg <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            caddr_reg   <= '0;
        end
        else
        begin
            if (tex_ok)
            begin
                in_cnt_reg  <= CW'(in_cnt_reg + 1'b1);
                in_addr_reg <= (in_addr_reg == AW'(DEPTH - 1)) ? '0 : AW'(in_addr_reg + 1'b1);
            end
            if (q_push)
            begin
                caddr_reg <= (caddr_reg == AW'(DEPTH - 1)) ? '0 : AW'(caddr_reg + 1'b1);
                if (is_last)
                begin
                    in_cnt_reg  <= '0;
                    enq_cnt_reg <= '0;
                    ox_reg      <= '0;
                    oy_reg      <= '0;
                end
                else
                begin
                    enq_cnt_reg <= CW'(enq_cnt_reg + 1'b1);
                    if (WW'(ox_reg) == WW'(w_reg - 1'b1))
                    begin
                        ox_reg <= '0;
                        oy_reg <= YW'(oy_reg + 1'b1);
                    end
                    else
                    begin
                        ox_reg <= XW'(ox_reg + 1'b1);
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/msnsf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msnsf_back
// Holds the texel store, gathers each 5x5 window one tap per cycle, divides
// and delivers the result item.
// ----------------------------------------------------------------------------
module msnsf_back #(
    parameter int MAX_WIDTH  = msnsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = msnsf_pkg::DEF_MAX_HEIGHT,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT + 1),
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1),
    parameter int AW = $clog2(4 * MAX_WIDTH + 8),
    parameter int EW = XW + YW + AW + 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  logic [EW-1:0]                   q_data,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic [1:0]                      wr_data,
    input  logic [WW-1:0]                   eff_w,
    input  logic [HW-1:0]                   eff_h,
    input  logic                            cfg_clear,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [msnsf_pkg::OUT_DATA_W-1:0] out_data,
    output logic                            out_last
);
    import msnsf_pkg::*;

    localparam int DEPTH = 4 * MAX_WIDTH + 8;
    localparam int SW = AW + 3;
    localparam int NXW = XW + 2;
    localparam int NYW = YW + 2;
    localparam logic signed [SW-1:0] DEPTH_S = SW'(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [1:0]            mem [DEPTH];
    logic [1:0]            rd_data_reg;
    logic [AW-1:0]         rd_addr;

    logic [2:0]            state_reg, state_next;
    logic [XW-1:0]         ox_reg;
    logic [YW-1:0]         oy_reg;
    logic [AW-1:0]         caddr_reg;
    logic                  last_reg;
    logic [4:0]            step_reg;
    logic [2:0]            kx_reg;
    logic [2:0]            ky_reg;
    logic                  pv_reg;
    logic                  pc_reg;
    logic [WEIGHT_W-1:0]   pw_reg;
    logic [SUM_W-1:0]      cov_reg;
    logic [SUM_W-1:0]      vsum_reg;
    logic                  mapped_reg;
    logic [SUM_W-1:0]      rem_reg;
    logic [VAL_W-1:0]      num_reg;
    logic [VAL_W-1:0]      quo_reg;
    logic [3:0]            bit_reg;
    logic                  seen_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    logic signed [2:0]     dx;
    logic signed [2:0]     dy;
    logic signed [NXW-1:0] nx;
    logic signed [NYW-1:0] ny;
    logic                  inframe;
    logic signed [SW-1:0]  wsx;
    logic signed [SW-1:0]  rowoff;
    logic signed [SW-1:0]  raw;
    logic signed [SW-1:0]  wrapped;
    logic                  issue;
    logic [SUM_W+VAL_W-1:0] num_full;
    logic [SUM_W:0]        trial;
    logic                  qbit;
    logic                  vis_hit;
    logic                  out_free;

    // Texel store: one write port from the front, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Neighbor position and store address of the current tap.
    assign dx  = $signed(kx_reg) - 3'sd2;
    assign dy  = $signed(ky_reg) - 3'sd2;
    assign nx  = $signed({2'b00, ox_reg}) + NXW'(dx);
    assign ny  = $signed({2'b00, oy_reg}) + NYW'(dy);
    assign inframe = (nx >= 0) && (nx < $signed(NXW'(eff_w)))
                  && (ny >= 0) && (ny < $signed(NYW'(eff_h)));
    assign wsx = $signed(SW'(eff_w));

    always_comb
    begin
        case (ky_reg)
            3'd0:    rowoff = -(wsx <<< 1);
            3'd1:    rowoff = -wsx;
            3'd3:    rowoff = wsx;
            3'd4:    rowoff = wsx <<< 1;
            default: rowoff = '0;
        endcase
        raw = $signed({3'b000, caddr_reg}) + rowoff + SW'(dx);
        if (raw < 0)
            wrapped = raw + DEPTH_S;
        else if (raw >= DEPTH_S)
            wrapped = raw - DEPTH_S;
        else
            wrapped = raw;
    end

    assign rd_addr = AW'(wrapped);
    assign issue   = (state_reg == ST_RUN) && (step_reg < 5'(KERNEL_TAPS));

    // Divider step and output bookkeeping.
    assign num_full = {vsum_reg, VAL_W'(0)} - (SUM_W+VAL_W)'(vsum_reg);
    assign trial    = {rem_reg, num_reg[VAL_W-1]};
    assign qbit     = (trial >= {1'b0, cov_reg});
    assign vis_hit  = mapped_reg && (vsum_reg != '0);
    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_RUN;
            ST_RUN:  if (step_reg == 5'(KERNEL_TAPS)) state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (bit_reg == 4'd15) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= issue && inframe;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                seen_reg      <= last_reg ? 1'b0 : (seen_reg || vis_hit);
            end
            if (cfg_clear)
            begin
                seen_reg <= 1'b0;
            end
        end
    end

    // Datapath registers of the job in flight.
    always_ff @(posedge clk)
    begin
        pw_reg <= kernel_weight(ky_reg, kx_reg);
        pc_reg <= (kx_reg == 3'd2) && (ky_reg == 3'd2);
        case (state_reg)
            ST_IDLE:
            begin
                {last_reg, caddr_reg, oy_reg, ox_reg} <= q_data;
                step_reg   <= '0;
                kx_reg     <= '0;
                ky_reg     <= '0;
                cov_reg    <= '0;
                vsum_reg   <= '0;
                mapped_reg <= 1'b0;
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    step_reg <= 5'(step_reg + 1'b1);
                    if (kx_reg == 3'(KERNEL_SIZE - 1))
                    begin
                        kx_reg <= '0;
                        ky_reg <= 3'(ky_reg + 1'b1);
                    end
                    else
                    begin
                        kx_reg <= 3'(kx_reg + 1'b1);
                    end
                end
                if (pv_reg && rd_data_reg[0])
                begin
                    cov_reg <= SUM_W'(cov_reg + pw_reg);
                    if (rd_data_reg[1])
                        vsum_reg <= SUM_W'(vsum_reg + pw_reg);
                    if (pc_reg)
                        mapped_reg <= 1'b1;
                end
            end
            ST_PREP:
            begin
                rem_reg <= num_full[SUM_W+VAL_W-1:VAL_W];
                num_reg <= num_full[VAL_W-1:0];
                bit_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= qbit ? SUM_W'(trial - {1'b0, cov_reg}) : SUM_W'(trial);
                num_reg <= {num_reg[VAL_W-2:0], 1'b0};
                quo_reg <= {quo_reg[VAL_W-2:0], qbit};
                bit_reg <= 4'(bit_reg + 1'b1);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg <= {6'b0,
                                     last_reg && !(seen_reg || vis_hit),
                                     mapped_reg,
                                     mapped_reg ? quo_reg : VAL_W'(0)};
                    out_last_reg <= last_reg;
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/masked_5x5_normalized_shadow_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_5x5_normalized_shadow_filter_unit
// Masked, normalized 5x5 filter over a raster-order stream of shadow texels.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis group: tuser selects a texel (0) or a drain tick
// (1), tdata carries the mapped and visible bits. Results leave on the
// m_axis group, one per texel, in raster order, with tlast on the final texel
// of the frame. The result for a texel is produced when the texel 2*W+2
// places later arrives; drain ticks after the frame push out the rest.
// For each result the back part reads the 25 window taps in turn through
// the single read port of the texel store, then takes a setup step and runs
// a one-bit-per-cycle divider for the 16-bit value, plus the output load.
// Items that cause no result are taken in one cycle each while the job queue
// has room. A two-entry queue parts the front from the back, and the output
// register lets the next job proceed while a result waits. When the receiver
// stalls, the back part holds its finished result and the queue fills, after
// which s_axis_tready drops. Reset sets both dimensions to 64 and starts a
// new frame; the texel store needs no clearing. A configuration write
// restarts the frame.
// ----------------------------------------------------------------------------
module masked_5x5_normalized_shadow_filter_unit #(
    parameter int MAX_WIDTH  = msnsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = msnsf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [msnsf_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // texel_mapped, texel_visible
    input  logic                             s_axis_tuser,  // command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [msnsf_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // filtered_visibility[15:0],
                                                            // out_mapped, fully_occluded
    output logic                             m_axis_tlast,
    input  logic                             cfg_we,
    input  logic [msnsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msnsf_pkg::CFG_W-1:0]      cfg_wdata
);
    import msnsf_pkg::*;

`include "masked_5x5_normalized_shadow_filter_unit_assert.svh"

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(4 * MAX_WIDTH + 8);
    localparam int EW = XW + YW + AW + 1;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [EW-1:0] q_in;
    logic [EW-1:0] q_out;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          cfg_clear;

    // Front: item intake and job classification.
    msnsf_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .XW(XW), .YW(YW), .WW(WW), .HW(HW), .AW(AW), .EW(EW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .command      (s_axis_tuser),
        .texel_mapped (s_axis_tdata[0]),
        .texel_visible(s_axis_tdata[1]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .eff_w        (eff_w),
        .eff_h        (eff_h),
        .cfg_clear    (cfg_clear)
    );

    // Job queue.
    msnsf_fifo #(
        .WIDTH(EW),
        .DEPTH(2)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .pop      (q_pop),
        .pop_data (q_out),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: window gather, divide and output.
    msnsf_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .XW(XW), .YW(YW), .WW(WW), .HW(HW), .AW(AW), .EW(EW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_data   (q_out),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .cfg_clear(cfg_clear),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

    // The queue never takes a job while full nor gives one while empty.
    `MSNSF_ASSERT_NEVER(a_q_no_overflow, clk, rst_n, q_push && q_full)
    `MSNSF_ASSERT_NEVER(a_q_no_underflow, clk, rst_n, q_pop && q_empty)
    // An unmapped result always carries a zero value.
    `MSNSF_ASSERT_NEVER(a_unmapped_zero, clk, rst_n,
        m_axis_tvalid && !m_axis_tdata[16] && (m_axis_tdata[15:0] != 16'd0))

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for masked_5x5_normalized_shadow_filter_unit
// Drives texel frames and drain ticks through the input stream under random
// idling and back pressure. A local 5x5 masked-filter predictor computes each
// expected result, and the output stream is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
    import msnsf_pkg::*;

    typedef enum bit {CMD_TEXEL = 1'b0, CMD_DRAIN = 1'b1} cmd_e;

    typedef struct {
        cmd_e cmd;
        bit   mapped;
        bit   visible;
    } texel_item_t;

    typedef struct {
        logic [15:0] shade;
        bit          mapped;
        bit          occluded;
        bit          last;
    } shade_result_t;

    localparam int STORE_D   = 4 * DEF_MAX_WIDTH + 8;
    localparam int HOLD_CYC  = 400;
    localparam int SETTLE    = 60;
    localparam int QUIET_LO  = 3000;
    localparam int QUIET_HI  = 7000;

    // Kernel weights indexed by row and column.
    localparam int unsigned KERN [5][5] = '{
        '{ 58,  85,  96,  85, 58},
        '{ 85, 123, 140, 123, 85},
        '{ 96, 140, 159, 140, 96},
        '{ 85, 123, 140, 123, 85},
        '{ 58,  85,  96,  85, 58}};

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    masked_5x5_normalized_shadow_filter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    texel_item_t   pending_texels[$];
    shade_result_t expected_shades[$];

    // Predictor state.
    logic [1:0]  texel_mem [STORE_D];
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    int unsigned texels_in;
    int unsigned shades_out;
    bit          any_lit;

    int unsigned cyc;
    int unsigned errors;
    int unsigned texels_taken;
    int unsigned shades_checked;
    int unsigned frames_done;
    int unsigned queued_texels;
    bit          taken_last;
    bit          hold_req;
    bit          hold_done;
    int unsigned hold_left;

    function automatic int unsigned cur_width();
        if (width_reg < 1) return 1;
        if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned cur_height();
        if (height_reg < 1) return 1;
        if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
        return height_reg;
    endfunction

    // Filter the texel at the output position and queue its result.
    function automatic void filter_next_texel();
        int unsigned w;
        int unsigned h;
        int          ox;
        int          oy;
        int          nx;
        int          ny;
        int unsigned cov;
        int unsigned vsum;
        logic [1:0]  cell_bits;
        shade_result_t r;
        w = cur_width();
        h = cur_height();
        ox = shades_out % w;
        oy = shades_out / w;
        cov = 0;
        vsum = 0;
        r.shade = '0;
        r.mapped = texel_mem[shades_out % STORE_D][0];
        r.last = (shades_out + 1 == w * h);
        if (r.mapped) begin
            for (int dy = -2; dy <= 2; dy++) begin
                for (int dx = -2; dx <= 2; dx++) begin
                    nx = ox + dx;
                    ny = oy + dy;
                    if (nx >= 0 && ny >= 0 && nx < int'(w) && ny < int'(h)) begin
                        cell_bits = texel_mem[(ny * w + nx) % STORE_D];
                        if (cell_bits[0]) begin
                            cov += KERN[dy + 2][dx + 2];
                            if (cell_bits[1]) vsum += KERN[dy + 2][dx + 2];
                        end
                    end
                end
            end
            if (vsum > 0) any_lit = 1;
            r.shade = 16'((longint'(vsum) * 65535) / cov);
        end
        r.occluded = r.last && !any_lit;
        expected_shades.push_back(r);
        if (r.last) begin
            texels_in = 0;
            shades_out = 0;
            any_lit = 0;
        end else begin
            shades_out++;
        end
    endfunction

    // Update the predictor for one accepted item.
    function automatic void predict_item(texel_item_t it);
        int unsigned total;
        int unsigned lag;
        int unsigned p;
        total = cur_width() * cur_height();
        lag = 2 * cur_width() + 2;
        if (it.cmd == CMD_TEXEL) begin
            if (texels_in >= total) return;
            p = texels_in;
            texel_mem[p % STORE_D] = {it.mapped & it.visible, it.mapped};
            texels_in++;
            if (p >= lag && shades_out == p - lag) filter_next_texel();
        end else if (texels_in >= total && shades_out < total) begin
            filter_next_texel();
        end
    endfunction

    // Clock and reset.
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    initial begin
        #10ms;
        $display("FAIL masked_5x5_normalized_shadow_filter_unit");
        $finish;
    end

    // Input handshake: accepted items feed the predictor.
    always @(posedge clk) begin
        cyc <= cyc + 1;
        taken_last <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_item(pending_texels[0]);
            pending_texels.pop_front();
            texels_taken <= texels_taken + 1;
        end
    end

    // Sender: offers the next pending item, idling at random.
    always @(negedge clk) begin
        if (rst_n && (!s_axis_tvalid || taken_last)) begin
            if (pending_texels.size() > 0 &&
                ((cyc > QUIET_LO && cyc < QUIET_HI) || $urandom_range(99) >= 34)) begin
                s_axis_tvalid <= 1;
                s_axis_tuser  <= pending_texels[0].cmd;
                s_axis_tdata  <= {6'b0, pending_texels[0].visible, pending_texels[0].mapped};
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_left <= HOLD_CYC;
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= (cyc > QUIET_LO && cyc < QUIET_HI) || $urandom_range(99) >= 34;
        end
    end

    // Output check against the oldest expected result.
    always @(posedge clk) begin
        shade_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_shades.size() == 0) begin
                $display("%0t: unexpected result: actual shade=%0d mapped=%0b occl=%0b last=%0b",
                         $time, m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[17],
                         m_axis_tlast);
                errors++;
            end else begin
                e = expected_shades.pop_front();
                shades_checked++;
                if (e.last) frames_done++;
                if (m_axis_tdata[15:0] !== e.shade) begin
                    $display("%0t: shade mismatch: expected %0d actual %0d",
                             $time, e.shade, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[16] !== e.mapped) begin
                    $display("%0t: mapped mismatch: expected %0b actual %0b",
                             $time, e.mapped, m_axis_tdata[16]);
                    errors++;
                end
                if (m_axis_tdata[17] !== e.occluded) begin
                    $display("%0t: occluded mismatch: expected %0b actual %0b",
                             $time, e.occluded, m_axis_tdata[17]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $display("%0t: last mismatch: expected %0b actual %0b",
                             $time, e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Wait until all items are taken and all results are back, then settle.
    task automatic wait_drained();
        while (pending_texels.size() != 0 || s_axis_tvalid || expected_shades.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write; only issued while the block is drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        texels_in = 0;
        shades_out = 0;
        any_lit = 0;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic set_dims(int unsigned w, int unsigned h);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
    endtask

    function automatic void add_item(cmd_e c, bit m, bit v);
        texel_item_t it;
        it.cmd = c;
        it.mapped = m;
        it.visible = v;
        pending_texels.push_back(it);
    endfunction

    // Queue one frame. Fill: 0 random, 1 all lit, 2 all mapped dark, 3 none
    // mapped. Optional pause halfway until every result is back.
    task automatic queue_frame(int fill, bit pause_mid, int unsigned limit);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned lag;
        int unsigned n;
        int unsigned drains;
        bit          m;
        bit          v;
        w = cur_width();
        h = cur_height();
        total = w * h;
        lag = 2 * w + 2;
        n = (limit != 0 && limit < total) ? limit : total;
        if ($urandom_range(3) == 0) add_item(CMD_DRAIN, $urandom_range(1), $urandom_range(1));
        for (int unsigned i = 0; i < n; i++) begin
            case (fill)
                1: begin m = 1; v = 1; end
                2: begin m = 1; v = $urandom_range(1) & 1'b0; end
                3: begin m = 0; v = $urandom_range(1); end
                default: begin m = ($urandom_range(3) != 0); v = $urandom_range(1); end
            endcase
            add_item(CMD_TEXEL, m, v);
            // Early drain ticks are dropped by the block.
            if (fill == 0 && i + 1 < n && $urandom_range(24) == 0)
                add_item(CMD_DRAIN, $urandom_range(1), $urandom_range(1));
            if (pause_mid && i == n / 2) wait_drained();
        end
        queued_texels += n;
        if (n < total) return;
        // A surplus texel is ignored while results are pending.
        if (total > lag || $urandom_range(1)) add_item(CMD_TEXEL, 1, 1);
        drains = (total > lag) ? lag : total;
        for (int unsigned i = 0; i < drains; i++)
            add_item(CMD_DRAIN, $urandom_range(1), $urandom_range(1));
    endtask

    initial begin
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 0;
        m_axis_tready = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_wdata = '0;
        cyc = 0;
        errors = 0;
        texels_taken = 0;
        shades_checked = 0;
        frames_done = 0;
        queued_texels = 0;
        taken_last = 0;
        hold_req = 0;
        hold_done = 0;
        hold_left = 0;
        width_reg = RESET_DIM;
        height_reg = RESET_DIM;
        texels_in = 0;
        shades_out = 0;
        any_lit = 0;
        for (int i = 0; i < STORE_D; i++) texel_mem[i] = '0;
        @(posedge rst_n);

        // Directed: small frames with all lit, all dark, none mapped, tiny.
        set_dims(3, 3);
        queue_frame(1, 0, 0);
        set_dims(1, 1);
        queue_frame(2, 0, 0);
        set_dims(2, 2);
        queue_frame(3, 0, 0);
        set_dims(5, 2);
        queue_frame(0, 0, 0);

        // Long receiver hold-off so the block fills and stalls its input.
        set_dims(16, 8);
        hold_req = 1;
        queue_frame(0, 0, 0);
        // Sender pause in mid-frame.
        queue_frame(0, 1, 0);

        // Random frames, back to back unless the size changes.
        while (queued_texels < 620) begin
            if ($urandom_range(2) == 0) begin
                if ($urandom_range(4) == 0)
                    set_dims($urandom_range(11, 40), $urandom_range(1, 8));
                else
                    set_dims($urandom_range(1, 10), $urandom_range(1, 10));
            end
            queue_frame($urandom_range(9) == 0 ? $urandom_range(1, 3) : 0, 0, 0);
        end

        // Extremes: zero acts as one, widest and tallest clamp, partial frames.
        set_dims(0, 0);
        queue_frame(1, 0, 0);
        set_dims(2047, 2047);
        queue_frame(0, 0, 40);
        set_dims(1, 2047);
        queue_frame(0, 0, 60);
        set_dims(7, 5);
        queue_frame(0, 0, 0);
        wait_drained();

        $display("Checked %0d results over %0d frames from %0d accepted items,",
                 shades_checked, frames_done, texels_taken);
        $display("with sizes from 1x1 to the clamped maxima, stalls and mid-frame pauses.");
        if (errors == 0)
            $display("PASS masked_5x5_normalized_shadow_filter_unit");
        else
            $display("FAIL masked_5x5_normalized_shadow_filter_unit");
        $finish;
    end

endmodule
